// ===== rtl/core/nge_pkg.sv =====
// nge_pkg: shared constants, register codes, state encoding and structs
// for the noise gate envelope block; no dependencies

package nge_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 24;

   localparam int CH_W       = 3;
   localparam int CH_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CNT_W      = 16;
   localparam int COEF_W     = 16;
   localparam int POW_W      = 32;
   localparam int GAIN_W     = 17;
   localparam int GAIN_FRAC  = 16;
   localparam int ACC_W      = 48;
   localparam int DIV_STEPS  = 16;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam int MUL_A_W    = 33;
   localparam int MUL_B_W    = (SAMPLE_BITS + 1 > 18) ? SAMPLE_BITS + 1 : 18;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

   localparam int SQ_FRAC    = 2 * (SAMPLE_BITS - 1);
   localparam int SQ_SHR     = (SQ_FRAC >= POW_W) ? SQ_FRAC - POW_W : 0;
   localparam int SQ_SHL     = (SQ_FRAC < POW_W) ? POW_W - SQ_FRAC : 0;
   localparam int SQ_W       = 2 * SAMPLE_BITS + SQ_SHL;

   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 4;

   localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'h10000;
   localparam logic [GAIN_W-1:0] GAIN_ZERO = 17'h00000;
   localparam logic [COEF_W:0]   COEF_ONE  = 17'h10000;

   localparam logic [COEF_W-1:0] RST_SMOOTHING = 16'd58982;
   localparam logic [POW_W-1:0]  RST_THRESHOLD = 32'd42950;
   localparam logic [CNT_W-1:0]  RST_ATTACK    = 16'd480;
   localparam logic [CNT_W-1:0]  RST_RELEASE   = 16'd24000;

   typedef enum logic [1:0] {
      REG_SMOOTHING = 2'd0,
      REG_THRESHOLD = 2'd1,
      REG_ATTACK    = 2'd2,
      REG_RELEASE   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] smoothing_coeff;
      logic [POW_W-1:0]  power_threshold;
      logic [CNT_W-1:0]  attack_len;
      logic [CNT_W-1:0]  release_len;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] num;
      logic [CNT_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] quo;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_MUL_GAIN,
      ST_MUL_SQ,
      ST_MUL_P1,
      ST_MUL_P2,
      ST_ADD,
      ST_UPDATE,
      ST_DONE
   } seq_state_type;

endpackage

// ===== rtl/core/nge_csr.sv =====
// nge_csr: configuration registers behind the apb-style port
// depends on nge_pkg

module nge_csr import nge_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [APB_ADDR_W-1:0] csr_paddr,
   input  logic [APB_DATA_W-1:0] csr_pwdata,
   output logic [APB_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type addr_idx;
   logic          wr_en;

   assign addr_idx   = reg_index_type'(csr_paddr[APB_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (addr_idx)
            REG_SMOOTHING: cfg_in.smoothing_coeff = csr_pwdata[COEF_W-1:0];
            REG_THRESHOLD: cfg_in.power_threshold = csr_pwdata[POW_W-1:0];
            REG_ATTACK:    cfg_in.attack_len      = csr_pwdata[CNT_W-1:0];
            REG_RELEASE:   cfg_in.release_len     = csr_pwdata[CNT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (addr_idx)
         REG_SMOOTHING: csr_prdata = APB_DATA_W'(cfg_ff.smoothing_coeff);
         REG_THRESHOLD: csr_prdata = APB_DATA_W'(cfg_ff.power_threshold);
         REG_ATTACK:    csr_prdata = APB_DATA_W'(cfg_ff.attack_len);
         REG_RELEASE:   csr_prdata = APB_DATA_W'(cfg_ff.release_len);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smoothing_coeff <= RST_SMOOTHING;
         cfg_ff.power_threshold <= RST_THRESHOLD;
         cfg_ff.attack_len      <= RST_ATTACK;
         cfg_ff.release_len     <= RST_RELEASE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/nge_div.sv =====
// nge_div: bit-serial restoring divider for the ramp gain, one quotient bit
// per cycle, gives floor(num * 65536 / den) for num < den; depends on nge_pkg

module nge_div import nge_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     den_ff, den_in;
   logic [CNT_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W:0]       trial;
   logic                 fits;

   assign trial = {rem_ff, 1'b0};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.num;
         den_in  = div_req.den;
         quo_in  = '0;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? CNT_W'(trial - {1'b0, den_ff}) : trial[CNT_W-1:0];
         quo_in = {quo_ff[CNT_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule

// ===== rtl/core/nge_mul.sv =====
// nge_mul: shared signed multiplier with registered product, used for the
// gain product, the square and both lowpass terms; depends on nge_pkg

module nge_mul import nge_pkg::*; (
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [MUL_P_W-1:0] prod
);

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/noise_gate_envelope.sv =====
// noise_gate_envelope: top level, sequencer, per-channel state and output word
// depends on nge_pkg, nge_csr, nge_div, nge_mul

// Multichannel noise gate. Each request word carries a channel and a signed
// sample; one response word comes back with the gated sample and the gate
// state of that channel. A word goes through load, a wait on the 16-step
// serial divider that forms the ramp gain while an attack or release ramp
// needs a division (none with no ramp, a release ramp at full gain or a zero
// length), four passes through the one shared multiplier (gain product,
// square, the two lowpass terms), sum, gate update and output. The block
// takes one word at a time and accepts the next one while the previous
// response still waits in the output register. The user must write
// configuration registers only while the block is idle; the block itself
// does not enforce this.

module noise_gate_envelope import nge_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [CH_W-1:0]               req_channel,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [CH_W-1:0]               rsp_out_channel,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   output logic                          rsp_gate_is_open,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [APB_ADDR_W-1:0]         csr_paddr,
   input  logic [APB_DATA_W-1:0]         csr_pwdata,
   output logic [APB_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   cfg_type       cfg;
   div_req_type   div_req;
   div_rsp_type   div_rsp;
   seq_state_type state_ff, state_in;

   logic [CH_W-1:0]               ch_ff, ch_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [GAIN_W-1:0]             gain_ff, gain_in;
   logic [CNT_W-1:0]              att_ff, att_in;
   logic [CNT_W-1:0]              rel_ff, rel_in;
   logic                          open_ff, open_in;
   logic [POW_W-1:0]              x2_ff, x2_in;
   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic [POW_W-1:0]              pow_new_ff, pow_new_in;
   logic [SAMPLE_BITS-1:0]        q_ff, q_in;
   logic                          open_new_ff, open_new_in;

   logic [POW_W-1:0] chan_power_ff [NUM_CHANNELS];
   logic [CNT_W-1:0] chan_att_ff   [NUM_CHANNELS];
   logic [CNT_W-1:0] chan_rel_ff   [NUM_CHANNELS];
   logic             chan_open_ff  [NUM_CHANNELS];

   logic             arr_we;
   logic [CNT_W-1:0] att_wr, rel_wr;
   logic             open_wr;

   logic                          rsp_valid_ff;
   logic                          rsp_load;
   logic [CH_W-1:0]               out_channel_ff;
   logic [SAMPLE_BITS-1:0]        out_sample_ff;
   logic                          gate_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;

   logic [CH_IDX_W-1:0]      idx;
   logic                     req_in_range;
   logic [CNT_W-1:0]         ld_a_left, ld_r_left, ld_len, ld_left, ld_clamp, ld_num;
   logic [SAMPLE_BITS-1:0]   mag;
   logic [2*SAMPLE_BITS-1:0] sq;
   logic [SQ_W-1:0]          sq_ext, sq_sh;
   logic [POW_W-1:0]         sq_sat;
   logic [ACC_W-1:0]         acc_sum;
   logic [COEF_W:0]          coef_rest;

   nge_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   nge_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   nge_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign idx          = CH_IDX_W'(ch_ff);
   assign req_in_range = int'(req_channel) < NUM_CHANNELS;

   // ramp selection from the stored counters
   assign ld_a_left = chan_att_ff[idx];
   assign ld_r_left = chan_rel_ff[idx];
   assign ld_len    = (ld_a_left != '0) ? cfg.attack_len : cfg.release_len;
   assign ld_left   = (ld_a_left != '0) ? ld_a_left : ld_r_left;
   assign ld_clamp  = (ld_left > ld_len) ? ld_len : ld_left;
   assign ld_num    = (ld_a_left != '0) ? ld_len - ld_clamp : ld_clamp;

   // square scaled to q0.32 with saturation
   assign mag    = sample_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_ff)
                                            : SAMPLE_BITS'(sample_ff);
   assign sq     = prod[2*SAMPLE_BITS-1:0];
   assign sq_ext = SQ_W'(sq) << SQ_SHL;
   assign sq_sh  = sq_ext >> SQ_SHR;
   assign sq_sat = (|sq_sh[SQ_W-1:POW_W]) ? '1 : sq_sh[POW_W-1:0];

   assign acc_sum   = acc_ff + prod[ACC_W-1:0];
   assign coef_rest = COEF_ONE - {1'b0, cfg.smoothing_coeff};

   always_comb begin
      state_in    = state_ff;
      ch_in       = ch_ff;
      sample_in   = sample_ff;
      gain_in     = gain_ff;
      att_in      = att_ff;
      rel_in      = rel_ff;
      open_in     = open_ff;
      x2_in       = x2_ff;
      acc_in      = acc_ff;
      pow_new_in  = pow_new_ff;
      q_in        = q_ff;
      open_new_in = open_new_ff;
      div_req     = '0;
      mul_a       = '0;
      mul_b       = '0;
      arr_we      = 1'b0;
      att_wr      = att_ff;
      rel_wr      = rel_ff;
      open_wr     = open_ff;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ch_in     = req_channel;
               sample_in = req_sample;
               if (req_in_range) begin
                  state_in = ST_LOAD;
               end else begin
                  q_in        = '0;
                  open_new_in = 1'b0;
                  state_in    = ST_DONE;
               end
            end
         end
         ST_LOAD: begin
            div_req.num = ld_num;
            div_req.den = ld_len;
            open_in     = chan_open_ff[idx];
            att_in      = ld_a_left;
            rel_in      = ld_r_left;
            state_in    = ST_MUL_GAIN;
            if (ld_a_left != '0) begin
               att_in = ld_a_left - 1'b1;
               if (ld_len == '0) begin
                  gain_in = GAIN_ONE;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIV;
               end
            end else if (ld_r_left != '0) begin
               rel_in = ld_r_left - 1'b1;
               if (ld_len == '0) begin
                  gain_in = GAIN_ZERO;
               end else if (ld_num == ld_len) begin
                  gain_in = GAIN_ONE;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIV;
               end
            end else begin
               gain_in = chan_open_ff[idx] ? GAIN_ONE : GAIN_ZERO;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               gain_in  = {1'b0, div_rsp.quo};
               state_in = ST_MUL_GAIN;
            end
         end
         ST_MUL_GAIN: begin
            mul_a    = MUL_A_W'(sample_ff);
            mul_b    = $signed(MUL_B_W'(gain_ff));
            state_in = ST_MUL_SQ;
         end
         ST_MUL_SQ: begin
            q_in     = prod[GAIN_FRAC +: SAMPLE_BITS];
            mul_a    = $signed(MUL_A_W'(mag));
            mul_b    = $signed(MUL_B_W'(mag));
            state_in = ST_MUL_P1;
         end
         ST_MUL_P1: begin
            x2_in    = sq_sat;
            mul_a    = $signed(MUL_A_W'(chan_power_ff[idx]));
            mul_b    = $signed(MUL_B_W'(cfg.smoothing_coeff));
            state_in = ST_MUL_P2;
         end
         ST_MUL_P2: begin
            acc_in   = prod[ACC_W-1:0];
            mul_a    = $signed(MUL_A_W'(x2_ff));
            mul_b    = $signed(MUL_B_W'(coef_rest));
            state_in = ST_ADD;
         end
         ST_ADD: begin
            pow_new_in = acc_sum[ACC_W-1:GAIN_FRAC];
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            arr_we = 1'b1;
            if (att_ff == '0 && rel_ff == '0) begin
               if (open_ff && pow_new_ff <= cfg.power_threshold) begin
                  open_wr = 1'b0;
                  rel_wr  = cfg.release_len;
               end else if (!open_ff && pow_new_ff > cfg.power_threshold) begin
                  open_wr = 1'b1;
                  att_wr  = cfg.attack_len;
               end
            end
            open_new_in = open_wr;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      sample_ff   <= sample_in;
      gain_ff     <= gain_in;
      att_ff      <= att_in;
      rel_ff      <= rel_in;
      open_ff     <= open_in;
      x2_ff       <= x2_in;
      acc_ff      <= acc_in;
      pow_new_ff  <= pow_new_in;
      q_ff        <= q_in;
      open_new_ff <= open_new_in;
   end

   // per-channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            chan_power_ff[i] <= '0;
            chan_att_ff[i]   <= '0;
            chan_rel_ff[i]   <= '0;
            chan_open_ff[i]  <= 1'b1;
         end
      end else if (arr_we) begin
         chan_power_ff[idx] <= pow_new_ff;
         chan_att_ff[idx]   <= att_wr;
         chan_rel_ff[idx]   <= rel_wr;
         chan_open_ff[idx]  <= open_wr;
      end
   end

   // response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         out_channel_ff <= ch_ff;
         out_sample_ff  <= q_ff;
         gate_ff        <= open_new_ff;
      end
   end

   assign req_ready        = state_ff == ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = out_channel_ff;
   assign rsp_out_sample   = out_sample_ff;
   assign rsp_gate_is_open = gate_ff;

   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a word is in flight");

   a_div_done_in_div: assert property (
      @(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

   a_one_ramp_only: assert property (
      @(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |=> !(chan_att_ff[idx] != '0 && chan_rel_ff[idx] != '0))
      else $error("attack and release ramps both running");

   a_out_of_range_closed: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && int'(rsp_out_channel) >= NUM_CHANNELS
      |-> !rsp_gate_is_open && rsp_out_sample == '0)
      else $error("unused channel returned a nonzero word");

endmodule

// ===== test/tb_noise_gate_envelope.sv =====
// tb_noise_gate_envelope: self-checking testbench for the noise gate envelope block
// holds a scoreboard class that predicts every gated word, plus tasks driving the
// request and csr ports; depends on nge_pkg and noise_gate_envelope

module tb_noise_gate_envelope;
   import nge_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [CH_W-1:0]               channel;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          gate_state;
   } gated_word_t;

   class gate_scoreboard;
      logic [COEF_W-1:0] smoothing;
      logic [POW_W-1:0]  threshold;
      logic [CNT_W-1:0]  attack_len;
      logic [CNT_W-1:0]  release_len;
      logic [POW_W-1:0]  power [NUM_CHANNELS];
      logic [CNT_W-1:0]  attack_left [NUM_CHANNELS];
      logic [CNT_W-1:0]  release_left [NUM_CHANNELS];
      logic              gate_state [NUM_CHANNELS];
      gated_word_t       expected_words [$];
      int                errors;

      function new();
         smoothing   = RST_SMOOTHING;
         threshold   = RST_THRESHOLD;
         attack_len  = RST_ATTACK;
         release_len = RST_RELEASE;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            power[i]        = '0;
            attack_left[i]  = '0;
            release_left[i] = '0;
            gate_state[i]   = 1'b1;
         end
         errors = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [APB_DATA_W-1:0] value);
         case (idx)
            REG_SMOOTHING: smoothing = value[COEF_W-1:0];
            REG_THRESHOLD: threshold = value[POW_W-1:0];
            REG_ATTACK:    attack_len = value[CNT_W-1:0];
            default:       release_len = value[CNT_W-1:0];
         endcase
      endfunction

      function logic [APB_DATA_W-1:0] register_value(reg_index_type idx);
         case (idx)
            REG_SMOOTHING: return APB_DATA_W'(smoothing);
            REG_THRESHOLD: return APB_DATA_W'(threshold);
            REG_ATTACK:    return APB_DATA_W'(attack_len);
            default:       return APB_DATA_W'(release_len);
         endcase
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void flag(string what, longint want, longint got);
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      endfunction

      // gated word and state update for one accepted request word
      function void note_request(logic [CH_W-1:0] ch, logic signed [SAMPLE_BITS-1:0] smp);
         gated_word_t       w;
         int                c;
         longint            s, len, left, gain, prod, q, frac;
         longint unsigned   mag, sq, acc, p;
         c = int'(ch);
         w.channel = ch;
         w.sample = '0;
         w.gate_state = 1'b0;
         if (c < NUM_CHANNELS) begin
            s = smp;
            if (attack_left[c] != 0) begin
               len = attack_len;
               left = attack_left[c];
               attack_left[c] = attack_left[c] - 1'b1;
               if (len == 0) begin
                  gain = 65536;
               end else begin
                  if (left > len) left = len;
                  gain = ((len - left) << 16) / len;
               end
            end else if (release_left[c] != 0) begin
               len = release_len;
               left = release_left[c];
               release_left[c] = release_left[c] - 1'b1;
               if (len == 0) begin
                  gain = 0;
               end else begin
                  if (left > len) left = len;
                  gain = (left << 16) / len;
               end
            end else begin
               gain = gate_state[c] ? 65536 : 0;
            end
            prod = s * gain;
            q = prod >>> 16;

            mag = (s < 0) ? -s : s;
            sq = mag * mag;
            frac = 2 * (SAMPLE_BITS - 1);
            if (frac >= 32) sq = sq >> (frac - 32);
            else sq = sq << (32 - frac);
            if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
            p = smoothing;
            acc = p * power[c] + (65536 - p) * sq;
            power[c] = acc[47:16];

            if (attack_left[c] == 0 && release_left[c] == 0) begin
               if (gate_state[c] && power[c] <= threshold) begin
                  gate_state[c] = 1'b0;
                  release_left[c] = release_len;
               end else if (!gate_state[c] && power[c] > threshold) begin
                  gate_state[c] = 1'b1;
                  attack_left[c] = attack_len;
               end
            end
            w.sample = q[SAMPLE_BITS-1:0];
            w.gate_state = gate_state[c];
         end
         expected_words.push_back(w);
      endfunction

      function void check_result(logic [CH_W-1:0] ch, logic signed [SAMPLE_BITS-1:0] smp,
                                 logic open);
         gated_word_t w;
         if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: unexpected word, expected none, actual channel %0d sample %0d",
                        $time, ch, smp);
            return;
         end
         w = expected_words.pop_front();
         if (ch !== w.channel) flag("out_channel", w.channel, ch);
         if (smp !== w.sample) flag("out_sample", w.sample, smp);
         if (open !== w.gate_state) flag("gate_is_open", w.gate_state, open);
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [CH_W-1:0]               req_channel;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [CH_W-1:0]               rsp_out_channel;
   logic signed [SAMPLE_BITS-1:0] rsp_out_sample;
   logic                          rsp_gate_is_open;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [APB_ADDR_W-1:0]         csr_paddr;
   logic [APB_DATA_W-1:0]         csr_pwdata;
   logic [APB_DATA_W-1:0]         csr_prdata;
   logic                          csr_pready;

   gate_scoreboard board;
   int             cycle_count = 0;
   bit             no_gaps = 1'b0;

   noise_gate_envelope u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_channel      (req_channel),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_out_sample   (rsp_out_sample),
      .rsp_gate_is_open (rsp_gate_is_open),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("noise_gate_envelope test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_out_channel, rsp_out_sample, rsp_gate_is_open);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(bit loud);
      int unsigned                   kind;
      logic signed [SAMPLE_BITS-1:0] v;
      kind = $urandom_range(0, 19);
      if (kind == 0) v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      else if (kind == 1) v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      else if (kind < 5) v = SAMPLE_BITS'($urandom);
      else if (loud) v = SAMPLE_BITS'($urandom_range(1 << 18, (1 << (SAMPLE_BITS - 1)) - 1));
      else v = SAMPLE_BITS'($urandom_range(0, 1 << 13));
      if (kind >= 5 && $urandom_range(0, 1)) v = -v;
      return v;
   endfunction

   // ready side: short runs with stalls, now and then a long steady stretch
   initial begin
      int span;
      forever begin
         span = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (span) @(posedge clock);
         span = pick_gap();
         if (span > 0) begin
            rsp_ready <= 1'b0;
            repeat (span) @(posedge clock);
         end
      end
   end

   task automatic send_word(logic [CH_W-1:0] ch, logic signed [SAMPLE_BITS-1:0] smp);
      int gap;
      req_valid <= 1'b1;
      req_channel <= ch;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      board.note_request(ch, smp);
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic write_register(reg_index_type idx, logic [APB_DATA_W-1:0] value);
      logic [APB_DATA_W-1:0] got;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_register(idx, value);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== board.register_value(idx))
         board.flag("register readback", board.register_value(idx), got);
      @(posedge clock);
   endtask

   task automatic apply_settings(logic [COEF_W-1:0] coeff, logic [POW_W-1:0] thr,
                                 logic [CNT_W-1:0] att, logic [CNT_W-1:0] rel);
      wait_drained();
      repeat (2) @(posedge clock);
      write_register(REG_SMOOTHING, APB_DATA_W'(coeff));
      write_register(REG_THRESHOLD, APB_DATA_W'(thr));
      write_register(REG_ATTACK, APB_DATA_W'(att));
      write_register(REG_RELEASE, APB_DATA_W'(rel));
   endtask

   // bursts on one channel with mostly one loudness, so gates open and close
   task automatic run_words(int count);
      int              n;
      int              burst;
      logic [CH_W-1:0] ch;
      bit              loud;
      n = 0;
      no_gaps = ($urandom_range(0, 3) == 0);
      while (n < count) begin
         ch = CH_W'($urandom);
         loud = 1'($urandom_range(0, 1));
         burst = $urandom_range(1, 10);
         repeat (burst) begin
            if (n < count) begin
               send_word(ch, pick_sample(($urandom_range(0, 7) == 0) ? !loud : loud));
               n++;
            end
         end
         if ($urandom_range(0, 40) == 0) wait_drained();
      end
   endtask

   task automatic random_settings();
      logic [COEF_W-1:0] coeff;
      logic [POW_W-1:0]  thr;
      logic [CNT_W-1:0]  att, rel;
      case ($urandom_range(0, 3))
         0: coeff = '0;
         1: coeff = '1;
         2: coeff = RST_SMOOTHING;
         default: coeff = COEF_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: thr = '0;
         1: thr = '1;
         2: thr = 32'd1 << $urandom_range(8, 30);
         default: thr = $urandom;
      endcase
      att = CNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12));
      rel = CNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12));
      apply_settings(coeff, thr, att, rel);
   endtask

   initial begin
      board = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_channel <= '0;
      req_sample <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // field extremes at the reset settings
      send_word(3'd0, 24'sh7FFFFF);
      send_word(3'd7, 24'sh800000);
      send_word(3'd0, 24'sh000000);
      send_word(3'd1, -24'sd1);
      send_word(3'd2, 24'sd1);
      send_word(3'd3, 24'sh555555);
      send_word(3'd4, 24'shAAAAAA);
      send_word(3'd5, 24'sh400000);
      send_word(3'd6, -24'sd4096);
      send_word(3'd7, 24'sh000000);
      send_word(3'd1, 24'sh7FFFFF);
      send_word(3'd1, 24'sh800000);
      send_word(3'd7, 24'sh7FFFFF);
      send_word(3'd0, 24'sh800000);

      apply_settings(16'd0, 32'd1 << 20, 16'd3, 16'd5);
      run_words(90);
      // zero ramp lengths
      apply_settings(16'd16384, 32'd1 << 18, 16'd0, 16'd0);
      run_words(80);
      apply_settings(16'hFFFF, 32'd0, 16'd1, 16'd1);
      run_words(60);
      apply_settings(16'd0, 32'hFFFF_FFFF, 16'd40, 16'd40);
      run_words(50);
      // ramps still running above the new, shorter lengths
      apply_settings(16'd0, 32'd1 << 20, 16'd2, 16'd3);
      run_words(80);
      repeat (4) begin
         random_settings();
         run_words(60);
      end
      apply_settings(16'd32768, 32'd0, 16'hFFFF, 16'hFFFF);
      run_words(40);

      wait_drained();
      repeat (40) @(posedge clock);
      if (board.errors == 0)
         $display("noise_gate_envelope test passed");
      else
         $display("noise_gate_envelope test failed");
      $finish;
   end

endmodule
